// ===== rtl/core/ldf_pkg.sv =====
`timescale 1ns / 1ps

package ldf_pkg;

   localparam int HEADER_BYTES = 4;
   localparam int QUEUE_DEPTH  = HEADER_BYTES + 1;

   localparam int HDR_IDX_W = $clog2(HEADER_BYTES);
   localparam int PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] HDR_LEN         = 16'(HEADER_BYTES);
   localparam logic [15:0] HDR_LEN_M1      = 16'(HEADER_BYTES - 1);
   localparam logic [15:0] MAX_SIZE_RESET  = 16'd1024;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       chunk_last;
   } ldf_req_type;

   typedef struct packed {
      logic [7:0]  packet_byte;
      logic        packet_end;
      logic        bad_size;
      logic [15:0] packet_length;
   } ldf_rsp_type;

   typedef enum logic [1:0] {
      CMD_BODY,
      CMD_HEADER,
      CMD_BAD
   } ldf_cmd_kind_type;

   typedef struct packed {
      ldf_cmd_kind_type                 kind;
      logic [HEADER_BYTES-1:0][7:0]     data;
      logic                             last_flag;
      logic [15:0]                      length;
   } ldf_cmd_type;

   typedef struct packed {
      logic        valid;
      ldf_cmd_type cmd;
   } ldf_push_type;

   typedef struct packed {
      logic        valid;
      ldf_cmd_type cmd;
   } ldf_head_type;

endpackage

// ===== rtl/core/ldf_front.sv =====
`timescale 1ns / 1ps

module ldf_front import ldf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  ldf_req_type  req_data,
   input  logic         queue_full,
   input  logic         csr_we,
   input  logic [15:0]  csr_wdata,
   output ldf_push_type push_out
);

   logic [15:0] bytes_taken_ff, bytes_taken_in;
   logic [15:0] expected_ff, expected_in;
   logic        dropping_ff, dropping_in;
   logic [15:0] max_size_ff;
   logic [7:0]  hdr_ff [HEADER_BYTES];
   logic        hdr_we;

   logic                         accept;
   logic [HEADER_BYTES-1:0][7:0] hdr_full;
   logic [15:0]                  decl_len;
   logic [15:0]                  eff_len;
   logic [15:0]                  taken_plus;

   assign accept = req_push && !queue_full;

   always_comb begin
      for (int i = 0; i < HEADER_BYTES; i++) begin
         hdr_full[i] = (i == HEADER_BYTES - 1) ? req_data.rx_byte : hdr_ff[i];
      end
   end

   assign decl_len   = {hdr_full[1], hdr_full[0]};
   assign eff_len    = (decl_len < HDR_LEN) ? HDR_LEN : decl_len;
   assign taken_plus = bytes_taken_ff + 16'd1;

   always_comb begin
      bytes_taken_in          = bytes_taken_ff;
      expected_in             = expected_ff;
      dropping_in             = dropping_ff;
      hdr_we                  = 1'b0;
      push_out.valid          = 1'b0;
      push_out.cmd.kind       = CMD_BODY;
      push_out.cmd.data       = hdr_full;
      push_out.cmd.last_flag  = 1'b0;
      push_out.cmd.length     = expected_ff;
      if (accept) begin
         if (dropping_ff) begin
            if (req_data.chunk_last) begin
               dropping_in = 1'b0;
            end
         end else if (bytes_taken_ff < HDR_LEN_M1) begin
            hdr_we         = 1'b1;
            bytes_taken_in = taken_plus;
         end else if (bytes_taken_ff == HDR_LEN_M1) begin
            push_out.valid      = 1'b1;
            push_out.cmd.length = eff_len;
            if (eff_len > max_size_ff) begin
               push_out.cmd.kind = CMD_BAD;
               bytes_taken_in    = 16'd0;
               expected_in       = 16'd0;
               dropping_in       = !req_data.chunk_last;
            end else begin
               push_out.cmd.kind      = CMD_HEADER;
               push_out.cmd.last_flag = (eff_len == HDR_LEN);
               expected_in            = eff_len;
               bytes_taken_in         = (eff_len == HDR_LEN) ? 16'd0 : HDR_LEN;
            end
         end else begin
            push_out.valid       = 1'b1;
            push_out.cmd.data[0] = req_data.rx_byte;
            if (taken_plus >= expected_ff) begin
               push_out.cmd.last_flag = 1'b1;
               bytes_taken_in         = 16'd0;
            end else begin
               bytes_taken_in = taken_plus;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_taken_ff <= 16'd0;
         expected_ff    <= 16'd0;
         dropping_ff    <= 1'b0;
         max_size_ff    <= MAX_SIZE_RESET;
      end else begin
         bytes_taken_ff <= bytes_taken_in;
         expected_ff    <= expected_in;
         dropping_ff    <= dropping_in;
         if (csr_we) begin
            max_size_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (hdr_we) begin
         hdr_ff[bytes_taken_ff[HDR_IDX_W-1:0]] <= req_data.rx_byte;
      end
   end

endmodule

// ===== rtl/core/ldf_queue.sv =====
`timescale 1ns / 1ps

module ldf_queue import ldf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  ldf_push_type push_in,
   input  logic         pop,
   output logic         full,
   output ldf_head_type head
);

   ldf_cmd_type      mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = mem_ff[rd_ptr_ff];

   assign do_push = push_in.valid && !full;
   assign do_pop  = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_in.cmd;
      end
   end

endmodule

// ===== rtl/core/ldf_back.sv =====
`timescale 1ns / 1ps

module ldf_back import ldf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  ldf_head_type head,
   output logic         pop,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output ldf_rsp_type  rsp_data
);

   logic [HDR_IDX_W-1:0] beat_ff, beat_in;
   logic                 out_valid_ff, out_valid_in;
   ldf_rsp_type          out_ff;
   ldf_rsp_type          result;
   logic                 load;
   logic                 last_beat;

   assign load      = head.valid && (!out_valid_ff || rsp_pop);
   assign last_beat = (head.cmd.kind != CMD_HEADER) ||
                      (beat_ff == HDR_IDX_W'(HEADER_BYTES - 1));
   assign pop       = load && last_beat;

   always_comb begin
      result.packet_length = head.cmd.length;
      unique case (head.cmd.kind)
         CMD_HEADER: begin
            result.packet_byte = head.cmd.data[beat_ff];
            result.packet_end  = head.cmd.last_flag &&
                                 (beat_ff == HDR_IDX_W'(HEADER_BYTES - 1));
            result.bad_size    = 1'b0;
         end
         CMD_BAD: begin
            result.packet_byte = 8'd0;
            result.packet_end  = 1'b0;
            result.bad_size    = 1'b1;
         end
         default: begin
            result.packet_byte = head.cmd.data[0];
            result.packet_end  = head.cmd.last_flag;
            result.bad_size    = 1'b0;
         end
      endcase
   end

   always_comb begin
      beat_in      = beat_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         beat_in      = last_beat ? '0 : beat_ff + 1'b1;
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         beat_ff      <= beat_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= result;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== rtl/core/length_prefixed_deframer.sv =====
// A body request is stored in the command queue, then in the output register. Each
// header in the size limit gives HEADER_BYTES results on consecutive cycles while
// rsp_pop holds, an oversized one a bad_size result; one request is taken per cycle
// unless full; the HEADER_BYTES + 1 entry queue absorbs backlog as a header drains.
// Reset is synchronous and active high; it empties the queue, clears the framing
// state and sets the maximum packet size to 1024.
`timescale 1ns / 1ps

module length_prefixed_deframer import ldf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  ldf_req_type req_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output ldf_rsp_type rsp_data,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   ldf_push_type push_cmd;
   ldf_head_type head;
   logic         queue_pop;

   ldf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_data   (req_data),
      .queue_full (req_full),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .push_out   (push_cmd)
   );

   ldf_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push_cmd),
      .pop     (queue_pop),
      .full    (req_full),
      .head    (head)
   );

   ldf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (queue_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== dv/tb_length_prefixed_deframer.sv =====
`timescale 1ns / 1ps

module tb_length_prefixed_deframer;
   import ldf_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 12;

   class frame_tracker;
      ldf_rsp_type due_bytes[$];
      logic [7:0]  hdr_bytes[HEADER_BYTES];
      logic [15:0] taken_count;
      logic [15:0] frame_length;
      logic [15:0] size_limit;
      bit          discarding;
      int          errors;

      function new();
         taken_count  = '0;
         frame_length = '0;
         size_limit   = MAX_SIZE_RESET;
         discarding   = 1'b0;
         errors       = 0;
         foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
      endfunction

      function void set_limit(logic [15:0] value);
         size_limit = value;
      endfunction

      function void queue_byte(logic [7:0] b, logic fin, logic bad, logic [15:0] len);
         ldf_rsp_type e;
         e.packet_byte   = b;
         e.packet_end    = fin;
         e.bad_size      = bad;
         e.packet_length = len;
         due_bytes.push_back(e);
      endfunction

      function void take_request(ldf_req_type r);
         logic [15:0] len;
         if (discarding) begin
            if (r.chunk_last) discarding = 1'b0;
            return;
         end
         if (taken_count < HDR_LEN) begin
            hdr_bytes[int'(taken_count)] = r.rx_byte;
            taken_count++;
            if (taken_count < HDR_LEN) return;
            len = {hdr_bytes[1], hdr_bytes[0]};
            if (len < HDR_LEN) len = HDR_LEN;
            if (len > size_limit) begin
               queue_byte(8'h00, 1'b0, 1'b1, len);
               taken_count  = '0;
               frame_length = '0;
               discarding   = !r.chunk_last;
               return;
            end
            frame_length = len;
            for (int i = 0; i < HEADER_BYTES; i++) begin
               queue_byte(hdr_bytes[i], (i == HEADER_BYTES - 1) && (len == HDR_LEN), 1'b0, len);
            end
            if (len == HDR_LEN) taken_count = '0;
            return;
         end
         taken_count++;
         if (taken_count >= frame_length) begin
            queue_byte(r.rx_byte, 1'b1, 1'b0, frame_length);
            taken_count = '0;
         end else begin
            queue_byte(r.rx_byte, 1'b0, 1'b0, frame_length);
         end
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task match_result(ldf_rsp_type got);
         ldf_rsp_type e;
         if (due_bytes.size() == 0) begin
            report($sformatf("unexpected result %h", got));
            return;
         end
         e = due_bytes.pop_front();
         if (got.packet_byte !== e.packet_byte)
            report($sformatf("packet_byte %h, expected %h", got.packet_byte, e.packet_byte));
         if (got.packet_end !== e.packet_end)
            report($sformatf("packet_end %b, expected %b", got.packet_end, e.packet_end));
         if (got.bad_size !== e.bad_size)
            report($sformatf("bad_size %b, expected %b", got.bad_size, e.bad_size));
         if (got.packet_length !== e.packet_length)
            report($sformatf("packet_length %h, expected %h", got.packet_length,
                             e.packet_length));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_push;
   logic        req_full;
   ldf_req_type req_data;
   logic        rsp_empty;
   logic        rsp_pop;
   ldf_rsp_type rsp_data;
   logic        csr_we;
   logic [15:0] csr_wdata;

   frame_tracker sb = new();
   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int hold_off_left  = 0;
   int sent_count     = 0;
   int cycle_count    = 0;

   length_prefixed_deframer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_length_prefixed_deframer: FAIL");
         $finish;
      end
   end

   // The receiver may be told to hold off for a stretch, which it counts down itself.
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            rsp_pop = 1'b0;
            hold_off_left--;
         end else begin
            rsp_pop = ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) sb.match_result(rsp_data);
   end

   task send_req(logic [7:0] b, logic last);
      ldf_req_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_push = 1'b0;
      end
      r.rx_byte    = b;
      r.chunk_last = last;
      @(negedge clock);
      req_push = 1'b1;
      req_data = r;
      do @(posedge clock); while (req_full);
      sb.take_request(r);
      sent_count++;
   endtask

   // Finishes whatever packet or dropped chunk is in progress.
   task resync();
      while (sb.taken_count != 0 || sb.discarding) begin
         if (sb.discarding) send_req(8'($urandom), $urandom_range(3) == 0);
         else send_req(8'($urandom), $urandom_range(7) == 0);
      end
   endtask

   task send_packet();
      logic [15:0] len;
      int pick;
      pick = $urandom_range(99);
      if (pick < 15) len = 16'($urandom_range(3));
      else if (pick < 70) len = 16'($urandom_range(12, 4));
      else if (pick < 85) len = 16'($urandom_range(40, 13));
      else if (sb.size_limit < 16'hFFFF) len = 16'($urandom_range(65535, int'(sb.size_limit) + 1));
      else len = 16'($urandom_range(200, 41));
      if (sb.size_limit <= 16'd64 && $urandom_range(99) < 8)
         send_req(8'($urandom), 1'($urandom_range(1)));
      send_req(len[7:0], $urandom_range(7) == 0);
      send_req(len[15:8], $urandom_range(7) == 0);
      send_req(8'($urandom), $urandom_range(7) == 0);
      send_req(8'($urandom), $urandom_range(2) == 0);
      resync();
   endtask

   task wait_idle();
      @(negedge clock);
      req_push = 1'b0;
      while (sb.due_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task run_phase(logic [15:0] limit_value, int send_pct, int stall_pct, int n_items,
                  int hold_cycles);
      int start;
      wait_idle();
      @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = limit_value;
      @(negedge clock);
      csr_we = 1'b0;
      sb.set_limit(limit_value);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      if (hold_cycles > 0) hold_off_left = hold_cycles;
      start = sent_count;
      while (sent_count - start < n_items) send_packet();
   endtask

   initial begin
      reset     = 1'b1;
      req_push  = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Header-only packet, then a zero length that is raised to the header size.
      send_req(8'h04, 1'b0); send_req(8'h00, 1'b0); send_req(8'h11, 1'b0); send_req(8'h22, 1'b1);
      send_req(8'h00, 1'b0); send_req(8'h00, 1'b0); send_req(8'hFF, 1'b0); send_req(8'h00, 1'b0);
      // A packet that spans three chunks.
      send_req(8'h06, 1'b0); send_req(8'h00, 1'b1); send_req(8'h01, 1'b0); send_req(8'h02, 1'b0);
      send_req(8'hFF, 1'b1); send_req(8'h80, 1'b0);
      // Oversized with the rest of the chunk dropped, then oversized at a chunk end.
      send_req(8'hFF, 1'b0); send_req(8'hFF, 1'b0); send_req(8'h00, 1'b0); send_req(8'h00, 1'b0);
      send_req(8'h7E, 1'b0); send_req(8'h01, 1'b1);
      send_req(8'h01, 1'b0); send_req(8'h04, 1'b0); send_req(8'h55, 1'b0); send_req(8'hAA, 1'b1);

      run_phase(16'd16, 0, 0, 60, 150);
      run_phase(16'hFFFF, 73, 0, 60, 0);
      run_phase(16'd4, 0, 73, 40, 0);
      run_phase(16'd3, 9, 9, 15, 0);
      run_phase(16'd40, 9, 9, 70, 0);
      wait_idle();

      if (sb.errors == 0) begin
         $display("tb_length_prefixed_deframer: PASS");
      end else begin
         $display("tb_length_prefixed_deframer: FAIL");
      end
      $finish;
   end

endmodule
